// File: hdl/pdtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtp_pkg
// Shared types, tag codes and the tag classifier for the PPPoE discovery
// tag parser.
// ----------------------------------------------------------------------------
package pdtp_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_TAG    = 2'd1,
        KIND_VENDOR = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    localparam logic [15:0] TAG_END_OF_LIST   = 16'h0000;
    localparam logic [15:0] TAG_SERVICE_NAME  = 16'h0101;
    localparam logic [15:0] TAG_AC_NAME       = 16'h0102;
    localparam logic [15:0] TAG_HOST_UNIQ     = 16'h0103;
    localparam logic [15:0] TAG_AC_COOKIE     = 16'h0104;
    localparam logic [15:0] TAG_VENDOR        = 16'h0105;
    localparam logic [15:0] TAG_RELAY_ID      = 16'h0110;
    localparam logic [15:0] TAG_SVC_NAME_ERR  = 16'h0201;
    localparam logic [15:0] TAG_AC_SYS_ERR    = 16'h0202;
    localparam logic [15:0] TAG_GENERIC_ERR   = 16'h0203;

    localparam logic [3:0] CLASS_SERVICE_NAME  = 4'd0;
    localparam logic [3:0] CLASS_AC_NAME       = 4'd1;
    localparam logic [3:0] CLASS_HOST_UNIQ     = 4'd2;
    localparam logic [3:0] CLASS_AC_COOKIE     = 4'd3;
    localparam logic [3:0] CLASS_VENDOR        = 4'd4;
    localparam logic [3:0] CLASS_RELAY_ID      = 4'd5;
    localparam logic [3:0] CLASS_SVC_NAME_ERR  = 4'd6;
    localparam logic [3:0] CLASS_AC_SYS_ERR    = 4'd7;
    localparam logic [3:0] CLASS_GENERIC_ERR   = 4'd8;
    localparam logic [3:0] CLASS_UNKNOWN_DATA  = 4'd9;
    localparam logic [3:0] CLASS_UNKNOWN_EMPTY = 4'd10;
    localparam logic [3:0] CLASS_NONE          = 4'd0;

    localparam int POS_W = 18;
    localparam logic [POS_W-1:0] POS_MAX       = 18'h3FFFF;
    localparam logic [POS_W-1:0] HDR_LAST_POS  = 18'd5;
    localparam logic [POS_W-1:0] HDR_BYTES     = 18'd6;
    localparam logic [POS_W-1:0] FIRST_TAG_POS = 18'd6;

    localparam int TDATA_W = 136;

    typedef struct packed {
        kind_t        kind;
        logic [3:0]   version;
        logic [3:0]   proto_type;
        logic [7:0]   code;
        logic [15:0]  sess_id;
        logic [15:0]  pay_len;
        logic [15:0]  tag_type;
        logic [15:0]  val_len;
        logic [16:0]  value_offset;
        logic [3:0]   tag_class;
        logic [31:0]  vend_num;
    } result_t;

    function automatic logic [3:0] classify(input logic [15:0] tag_type,
                                            input logic [15:0] tag_len);
        logic [3:0] cls;
        case (tag_type)
            TAG_SERVICE_NAME: cls = CLASS_SERVICE_NAME;
            TAG_AC_NAME:      cls = CLASS_AC_NAME;
            TAG_HOST_UNIQ:    cls = CLASS_HOST_UNIQ;
            TAG_AC_COOKIE:    cls = CLASS_AC_COOKIE;
            TAG_VENDOR:       cls = CLASS_VENDOR;
            TAG_RELAY_ID:     cls = CLASS_RELAY_ID;
            TAG_SVC_NAME_ERR: cls = CLASS_SVC_NAME_ERR;
            TAG_AC_SYS_ERR:   cls = CLASS_AC_SYS_ERR;
            TAG_GENERIC_ERR:  cls = CLASS_GENERIC_ERR;
            default: begin
                cls = (tag_len != 16'd0) ? CLASS_UNKNOWN_DATA : CLASS_UNKNOWN_EMPTY;
            end
        endcase
        return cls;
    endfunction

endpackage

// File: hdl/pdtp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtp_front
// Byte-level parser: tracks the frame offset, collects the header, walks the
// tag list and registers at most one result per byte for the queue.
// ----------------------------------------------------------------------------
module pdtp_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              frame_start,
    output logic              res_valid,
    output pdtp_pkg::result_t res_data,
    input  logic              q_ready
);
    import pdtp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [39:0]      hdr_reg, hdr_next;
    logic             walk_reg, walk_next;
    logic [POS_W-1:0] nts_reg, nts_next;
    logic [31:0]      ths_reg, ths_next;
    logic [31:0]      vsh_reg, vsh_next;
    logic             res_valid_reg, res_valid_next;
    result_t          res_data_reg, res_data_next;

    // State as seen by this byte, after a possible frame restart
    logic [POS_W-1:0] cur_pos, cur_nts;
    logic [39:0]      cur_hdr;
    logic             cur_walk;
    logic [31:0]      cur_ths, cur_vsh;

    logic [POS_W:0]   pos_w, tag_w, vs_w;
    logic [POS_W-1:0] vs_pos;
    logic [31:0]      ths_new, vsh_new;
    logic [15:0]      plen_now, plen_hdr;
    logic [15:0]      cur_type, cur_len, new_type, new_len;
    logic             accept, in_tag_hdr, vendor_ok, in_vendor;

    assign accept   = in_valid && in_ready;
    assign in_ready = !res_valid_reg || q_ready;

    always_comb begin
        cur_pos  = frame_start ? '0 : pos_reg;
        cur_hdr  = frame_start ? '0 : hdr_reg;
        cur_walk = frame_start ? 1'b0 : walk_reg;
        cur_nts  = frame_start ? FIRST_TAG_POS : nts_reg;
        cur_ths  = frame_start ? '0 : ths_reg;
        cur_vsh  = frame_start ? '0 : vsh_reg;
    end

    always_comb begin
        pos_w      = {1'b0, cur_pos};
        tag_w      = {1'b0, cur_nts};
        ths_new    = {cur_ths[23:0], data_byte};
        vsh_new    = {cur_vsh[23:0], data_byte};
        new_type   = ths_new[31:16];
        new_len    = ths_new[15:0];
        cur_type   = cur_ths[31:16];
        cur_len    = cur_ths[15:0];
        plen_now   = {cur_hdr[7:0], data_byte};
        plen_hdr   = cur_hdr[15:0];
        in_tag_hdr = (pos_w >= tag_w) && (pos_w <= tag_w + 19'd3);
        vendor_ok  = (cur_type == TAG_VENDOR) && (cur_len >= 16'd4)
                     && (cur_nts >= {2'b00, cur_len});
        vs_pos     = cur_nts - {2'b00, cur_len};
        vs_w       = {1'b0, vs_pos};
        in_vendor  = vendor_ok && (pos_w >= vs_w) && (pos_w <= vs_w + 19'd3);
    end

    always_comb begin
        pos_next       = pos_reg;
        hdr_next       = hdr_reg;
        walk_next      = walk_reg;
        nts_next       = nts_reg;
        ths_next       = ths_reg;
        vsh_next       = vsh_reg;
        res_valid_next = res_valid_reg && !q_ready;
        res_data_next  = res_data_reg;

        if (accept) begin
            pos_next       = (cur_pos < POS_MAX) ? cur_pos + 1'b1 : cur_pos;
            hdr_next       = cur_hdr;
            walk_next      = cur_walk;
            nts_next       = cur_nts;
            ths_next       = cur_ths;
            vsh_next       = cur_vsh;
            res_valid_next = 1'b0;
            res_data_next  = '0;

            if (cur_pos < HDR_BYTES) begin
                hdr_next = {cur_hdr[31:0], data_byte};
                if (cur_pos == HDR_LAST_POS) begin
                    res_valid_next               = 1'b1;
                    res_data_next.kind           = KIND_HEADER;
                    res_data_next.version        = cur_hdr[39:36];
                    res_data_next.proto_type     = cur_hdr[35:32];
                    res_data_next.code           = cur_hdr[31:24];
                    res_data_next.sess_id        = cur_hdr[23:8];
                    res_data_next.pay_len        = plen_now;
                    walk_next                    = (plen_now != 16'd0);
                    nts_next                     = FIRST_TAG_POS;
                end
            end else if (cur_walk) begin
                if (in_tag_hdr) begin
                    ths_next = ths_new;
                    if (pos_w == tag_w + 19'd3) begin
                        if (tag_w > {3'b000, plen_hdr} + 19'd4) begin
                            // tag starts at or beyond the last payload byte: stop without a result
                            walk_next = 1'b0;
                        end else if (new_type == TAG_END_OF_LIST) begin
                            res_valid_next             = 1'b1;
                            res_data_next.kind         = KIND_END;
                            res_data_next.tag_type     = new_type;
                            res_data_next.val_len      = new_len;
                            res_data_next.value_offset = 17'(tag_w + 19'd4);
                            res_data_next.tag_class    = CLASS_NONE;
                            walk_next                  = 1'b0;
                        end else begin
                            res_valid_next             = 1'b1;
                            res_data_next.kind         = KIND_TAG;
                            res_data_next.tag_type     = new_type;
                            res_data_next.val_len      = new_len;
                            res_data_next.value_offset = 17'(tag_w + 19'd4);
                            res_data_next.tag_class    = classify(new_type, new_len);
                            nts_next = cur_nts + 18'd4 + {2'b00, new_len};
                            vsh_next = '0;
                        end
                    end
                end else if (in_vendor) begin
                    vsh_next = vsh_new;
                    if (pos_w == vs_w + 19'd3) begin
                        res_valid_next             = 1'b1;
                        res_data_next.kind         = KIND_VENDOR;
                        res_data_next.tag_type     = cur_type;
                        res_data_next.val_len      = cur_len;
                        res_data_next.value_offset = vs_pos[16:0];
                        res_data_next.tag_class    = CLASS_VENDOR;
                        res_data_next.vend_num     = vsh_new;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            hdr_reg       <= '0;
            walk_reg      <= 1'b0;
            nts_reg       <= FIRST_TAG_POS;
            ths_reg       <= '0;
            vsh_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            hdr_reg       <= hdr_next;
            walk_reg      <= walk_next;
            nts_reg       <= nts_next;
            ths_reg       <= ths_next;
            vsh_reg       <= vsh_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// File: hdl/pdtp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdtp_queue
// Small result queue between the parser and the output channel; the head
// entry drives the output directly.
// ----------------------------------------------------------------------------
module pdtp_queue #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  pdtp_pkg::result_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output pdtp_pkg::result_t pop_data
);
    import pdtp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/pppoe_discovery_tag_parser.sv
`timescale 1ns / 1ps
// A result is registered in the parser, then stored in the queue, whose head drives m_.
// Throughput: one frame byte per cycle unless a result waits on a full queue;
// each byte needs one offset compare and counter update in the parser.
// The result queue (QUEUE_DEPTH entries) absorbs output stalls.
// Reset: synchronous, active-low aresetn; the parse restarts at offset 0.
// ----------------------------------------------------------------------------
// pppoe_discovery_tag_parser
// Parses a PPPoE discovery frame byte stream into header, tag, vendor id and
// end-of-list result items.
// ----------------------------------------------------------------------------
module pppoe_discovery_tag_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,  // [7:0] data_byte
    input  logic         s_tuser,  // [0] frame_start
    output logic         m_tvalid,
    input  logic         m_tready,
    // [3:0] version, [7:4] proto_type, [15:8] code, [31:16] sess_id,
    // [47:32] pay_len, [63:48] tag_type, [79:64] val_len,
    // [96:80] value_offset, [100:97] tag_class, [132:101] vend_num, rest zero
    output logic [pdtp_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]   m_tuser   // [1:0] result_kind
);
    import pdtp_pkg::*;

    logic    res_valid, q_ready;
    result_t res_data, head;

    pdtp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .data_byte   (s_tdata),
        .frame_start (s_tuser),
        .res_valid   (res_valid),
        .res_data    (res_data),
        .q_ready     (q_ready)
    );

    pdtp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (res_valid),
        .push_ready (q_ready),
        .push_data  (res_data),
        .pop_valid  (m_tvalid),
        .pop_ready  (m_tready),
        .pop_data   (head)
    );

    assign m_tuser = head.kind;
    assign m_tdata = {3'b000, head.vend_num, head.tag_class, head.value_offset,
                      head.val_len, head.tag_type, head.pay_len,
                      head.sess_id, head.code, head.proto_type, head.version};

    a_vendor_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && head.kind == KIND_VENDOR)
            |-> (head.tag_class == CLASS_VENDOR && head.tag_type == TAG_VENDOR))
        else $error("vendor result with wrong class or type");

    a_header_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && head.kind == KIND_HEADER)
            |-> (head.tag_type == '0 && head.val_len == '0
                 && head.value_offset == '0 && head.vend_num == '0))
        else $error("header result carries tag fields");

    a_end_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && head.kind == KIND_END)
            |-> (head.tag_type == TAG_END_OF_LIST && head.tag_class == CLASS_NONE))
        else $error("end-of-list result with non-zero type or class");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && res_valid))
        else $error("input stalled while the queue can take a result");

endmodule
